// ----- design/activation_function_unit_macros.svh -----
// Assertion macros used by the checker file of the activation function unit.
`ifndef ACTIVATION_FUNCTION_UNIT_MACROS_SVH
`define ACTIVATION_FUNCTION_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AFU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An implication that must hold at every clock edge outside reset.
`define AFU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/afu_pkg.sv -----
`timescale 1ns / 1ps

package afu_pkg;

  // Datapath geometry.
  localparam int LANES      = 4;
  localparam int DATA_W     = 16;
  localparam int FRAC_BITS  = 12;
  localparam int OP_W       = 3;
  localparam int SIG_W      = FRAC_BITS + 1;
  localparam int SEG_BITS   = 6;
  localparam int SEG_FRAC_W = DATA_W - SEG_BITS;
  localparam int KNOT_W     = SEG_BITS + 1;
  localparam int PROD_W     = 2 * SIG_W;

  // Fixed-point one and one half in the result format.
  localparam logic [SIG_W-1:0] ONE  = SIG_W'(1 << FRAC_BITS);
  localparam logic [SIG_W-1:0] HALF = SIG_W'(1 << (FRAC_BITS - 1));

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_LINEAR    = 3'd0,
    OP_LINEAR_D  = 3'd1,
    OP_SIGMOID   = 3'd2,
    OP_SIGMOID_D = 3'd3,
    OP_RELU      = 3'd4,
    OP_RELU_D    = 3'd5
  } op_e;

  // Sigmoid knot values, Q.12, at x = -8.0 + k/4 for k = 0..64.
  function automatic logic [SIG_W-1:0] knot_value(input logic [KNOT_W-1:0] k);
    logic [SIG_W-1:0] v;
    case (k)
      7'd0:  v = 13'd1;    7'd1:  v = 13'd2;    7'd2:  v = 13'd2;    7'd3:  v = 13'd3;
      7'd4:  v = 13'd4;    7'd5:  v = 13'd5;    7'd6:  v = 13'd6;    7'd7:  v = 13'd8;
      7'd8:  v = 13'd10;   7'd9:  v = 13'd13;   7'd10: v = 13'd17;   7'd11: v = 13'd21;
      7'd12: v = 13'd27;   7'd13: v = 13'd35;   7'd14: v = 13'd45;   7'd15: v = 13'd58;
      7'd16: v = 13'd74;   7'd17: v = 13'd94;   7'd18: v = 13'd120;  7'd19: v = 13'd153;
      7'd20: v = 13'd194;  7'd21: v = 13'd246;  7'd22: v = 13'd311;  7'd23: v = 13'd391;
      7'd24: v = 13'd488;  7'd25: v = 13'd606;  7'd26: v = 13'd747;  7'd27: v = 13'd912;
      7'd28: v = 13'd1102; 7'd29: v = 13'd1314; 7'd30: v = 13'd1546; 7'd31: v = 13'd1793;
      7'd32: v = 13'd2048; 7'd33: v = 13'd2303; 7'd34: v = 13'd2550; 7'd35: v = 13'd2782;
      7'd36: v = 13'd2994; 7'd37: v = 13'd3184; 7'd38: v = 13'd3349; 7'd39: v = 13'd3490;
      7'd40: v = 13'd3608; 7'd41: v = 13'd3705; 7'd42: v = 13'd3785; 7'd43: v = 13'd3850;
      7'd44: v = 13'd3902; 7'd45: v = 13'd3943; 7'd46: v = 13'd3976; 7'd47: v = 13'd4002;
      7'd48: v = 13'd4022; 7'd49: v = 13'd4038; 7'd50: v = 13'd4051; 7'd51: v = 13'd4061;
      7'd52: v = 13'd4069; 7'd53: v = 13'd4075; 7'd54: v = 13'd4079; 7'd55: v = 13'd4083;
      7'd56: v = 13'd4086; 7'd57: v = 13'd4088; 7'd58: v = 13'd4090; 7'd59: v = 13'd4091;
      7'd60: v = 13'd4092; 7'd61: v = 13'd4093; 7'd62: v = 13'd4094; 7'd63: v = 13'd4094;
      7'd64: v = 13'd4095;
      default: v = ONE;
    endcase
    return v;
  endfunction

endpackage

// ----- design/afu_lane.sv -----
`timescale 1ns / 1ps

module afu_lane import afu_pkg::*; (
  input  logic                     clk_i,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [DATA_W-1:0] x_i,
  output logic [DATA_W-1:0]        y_o
);

  // Stage one: segment lookup.
  logic [DATA_W-1:0]     u;
  logic [KNOT_W-1:0]     seg;
  logic [SIG_W-1:0]      v0, v1;
  logic [OP_W-1:0]       op1_q, op2_q;
  logic [DATA_W-1:0]     x1_q, x2_q;
  logic [SIG_W-1:0]      base_q, dlt_q;
  logic [SEG_FRAC_W-1:0] frac_q;

  // Offset the input so that segment zero starts at the most negative value.
  assign u   = {~x_i[DATA_W-1], x_i[DATA_W-2:0]};
  assign seg = KNOT_W'(u[DATA_W-1 -: SEG_BITS]);
  assign v0  = knot_value(seg);
  assign v1  = knot_value(seg + KNOT_W'(1));

  always_ff @(posedge clk_i) begin
    op1_q  <= op_i;
    x1_q   <= x_i;
    base_q <= v0;
    dlt_q  <= v1 - v0;
    frac_q <= u[SEG_FRAC_W-1:0];
  end

  // Stage two: linear interpolation inside the segment, then saturation.
  logic [SIG_W+SEG_FRAC_W-1:0] interp;
  logic [SIG_W:0]              s_sum;
  logic [SIG_W-1:0]            s_d, s_q;

  assign interp = SIG_W'(dlt_q) * (SIG_W+SEG_FRAC_W)'(frac_q);
  assign s_sum  = (SIG_W+1)'(base_q) + (SIG_W+1)'(interp >> SEG_FRAC_W);

  always_comb begin
    if (s_sum > (SIG_W+1)'(ONE)) begin
      s_d = ONE;
    end else begin
      s_d = s_sum[SIG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q <= op1_q;
    x2_q  <= x1_q;
    s_q   <= s_d;
  end

  // Stage three: derivative of the sigmoid and the result select.
  logic [PROD_W-1:0] deriv_p;
  logic [PROD_W-1:0] deriv;

  assign deriv_p = PROD_W'(s_q) * PROD_W'(ONE - s_q);
  assign deriv   = (deriv_p + PROD_W'(HALF)) >> FRAC_BITS;

  always_comb begin
    case (op_e'(op2_q))
      OP_LINEAR:    y_o = x2_q;
      OP_LINEAR_D:  y_o = DATA_W'(ONE);
      OP_SIGMOID:   y_o = DATA_W'(s_q);
      OP_SIGMOID_D: y_o = deriv[DATA_W-1:0];
      OP_RELU:      y_o = x2_q[DATA_W-1] ? '0 : x2_q;
      OP_RELU_D:    y_o = (!x2_q[DATA_W-1] && (x2_q != '0)) ? DATA_W'(ONE) : '0;
      default:      y_o = '0;
    endcase
  end

endmodule

// ----- design/activation_function_unit.sv -----
// Four-lane activation unit: every accepted item applies one op (linear, sigmoid,
// ReLU or a derivative) to four Q3.12 values. A new item can be started in every
// cycle; busy_o never rises. The result appears on y0_o..y3_o with done_o high for
// exactly one cycle. The valid bit of an accepted item passes through vld_q[0] and
// vld_q[1] to done_q, and the result is valid while done_o is high. The receiver must
// take it then because the unit cannot be stalled. The data passes through two lane
// pipeline registers, one after the knot lookup and one after the interpolation
// multiply, and then through the output register that merges the lanes. The
// sigmoid-derivative multiply and the result select sit in front of the output
// register.
`timescale 1ns / 1ps

module activation_function_unit import afu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [DATA_W-1:0] x0_i,
  input  logic signed [DATA_W-1:0] x1_i,
  input  logic signed [DATA_W-1:0] x2_i,
  input  logic signed [DATA_W-1:0] x3_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] y0_o,
  output logic signed [DATA_W-1:0] y1_o,
  output logic signed [DATA_W-1:0] y2_o,
  output logic signed [DATA_W-1:0] y3_o
);

  // The pipeline never holds off a transfer.
  assign busy_o = 1'b0;

  logic signed [DATA_W-1:0] x_lane [LANES];
  logic [DATA_W-1:0]        y_lane [LANES];
  logic [DATA_W-1:0]        y_q    [LANES];

  assign x_lane[0] = x0_i;
  assign x_lane[1] = x1_i;
  assign x_lane[2] = x2_i;
  assign x_lane[3] = x3_i;

  // One pipelined core per lane.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    afu_lane u_lane (
      .clk_i (clk_i),
      .op_i  (op_i),
      .x_i   (x_lane[i]),
      .y_o   (y_lane[i])
    );
  end

  // Valid tracking alongside the two lane stages.
  logic [1:0] vld_q;
  logic       done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[0], start_i && !busy_o};
      done_q <= vld_q[1];
    end
  end

  // Merge stage: the lane results are captured together into the output register.
  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      y_q <= y_lane;
    end
  end

  assign done_o = done_q;
  assign y0_o   = y_q[0];
  assign y1_o   = y_q[1];
  assign y2_o   = y_q[2];
  assign y3_o   = y_q[3];

endmodule

// ----- design/afu_checker.sv -----
`timescale 1ns / 1ps
`include "activation_function_unit_macros.svh"

module afu_checker import afu_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic [OP_W-1:0]          op_i,
  input logic signed [DATA_W-1:0] x0_i,
  input logic                     done_o,
  input logic signed [DATA_W-1:0] y0_o,
  input logic signed [DATA_W-1:0] y3_o
);

  // Every accepted item is followed by its result with done_o high.
  `AFU_ASSERT_IMP(a_item_done, clk_i, rst_ni, start_i && !busy_o, ##3 done_o, "accepted item produced no result")

  // No result appears without an accepted item before it.
  `AFU_ASSERT_IMP(a_done_has_item, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 3), "result without an accepted item")

  // The linear op passes the lane value through unchanged.
  `AFU_ASSERT_IMP(a_linear, clk_i, rst_ni, done_o && ($past(op_i, 3) == OP_LINEAR), y0_o == $past(x0_i, 3), "linear result differs from input")

  // The ReLU derivative is either zero or one.
  `AFU_ASSERT_IMP(a_relu_d, clk_i, rst_ni, done_o && ($past(op_i, 3) == OP_RELU_D), (y3_o == 16'sd0) || (y3_o == 16'sd4096), "ReLU derivative out of set")

endmodule

bind activation_function_unit afu_checker u_afu_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .op_i    (op_i),
  .x0_i    (x0_i),
  .done_o  (done_o),
  .y0_o    (y0_o),
  .y3_o    (y3_o)
);
